FILE: sv/chunked_body_decoder_top_assert.svh
// Assertion macros shared by the chunked body decoder.
`ifndef CHUNKED_BODY_DECODER_TOP_ASSERT_SVH
`define CHUNKED_BODY_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define CBD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chunked body decoder: same-cycle check failed");

// Next-cycle implication, checked only while out of reset.
`define CBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chunked body decoder: next-cycle check failed");

`endif

FILE: sv/cbd_pkg.sv
package cbd_pkg;

  typedef enum logic [3:0] {
    PH_FIRST   = 4'd0,
    PH_DIGITS  = 4'd1,
    PH_SKIP    = 4'd2,
    PH_DATA    = 4'd3,
    PH_CR      = 4'd4,
    PH_LF      = 4'd5,
    PH_TRAILER = 4'd6,
    PH_DONE    = 4'd7,
    PH_ERROR   = 4'd8
  } phase_t;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_NUL  = 8'h00;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_FRAMING   = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       finished;
    logic [1:0] error_code;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

  function automatic logic ends_number(input logic [7:0] c);
    return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR) || (c == CH_SEMI) || (c == CH_NUL);
  endfunction

endpackage

FILE: sv/cbd_core.sv
module cbd_core import cbd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       conn_closed,
  output result_t    result
);

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] chunk_remaining, chunk_remaining_next;
  logic                 terminator_bad, terminator_bad_next;
  logic [1:0]           sticky_error, sticky_error_next;

  hex_digit_t hex;
  logic       size_overflow;

  assign hex           = hex_decode(byte_in);
  // Shifting in one more digit overflows exactly when the top nibble is nonzero.
  assign size_overflow = |chunk_remaining[SIZE_BITS-1 -: 4];

  always_comb begin
    phase_next           = phase;
    chunk_remaining_next = chunk_remaining;
    terminator_bad_next  = terminator_bad;
    sticky_error_next    = sticky_error;
    if (phase != PH_DONE && phase != PH_ERROR && conn_closed) begin
      sticky_error_next = ERR_TRUNCATED;
      phase_next        = PH_ERROR;
    end else if (!conn_closed) begin
      unique case (phase) inside
        PH_FIRST: begin
          chunk_remaining_next = '0;
          terminator_bad_next  = 1'b0;
          if (byte_in == CH_LF) begin
            sticky_error_next = ERR_FRAMING;
            phase_next        = PH_ERROR;
          end else if (hex.valid) begin
            chunk_remaining_next = SIZE_BITS'(hex.value);
            phase_next           = PH_DIGITS;
          end else begin
            terminator_bad_next = 1'b1;
            phase_next          = PH_SKIP;
          end
        end
        PH_DIGITS, PH_SKIP: begin
          if (byte_in == CH_LF) begin
            if (terminator_bad) begin
              sticky_error_next = ERR_FRAMING;
              phase_next        = PH_ERROR;
            end else if (chunk_remaining == '0) begin
              phase_next = PH_TRAILER;
            end else begin
              phase_next = PH_DATA;
            end
          end else if (phase == PH_DIGITS) begin
            if (ends_number(byte_in)) begin
              phase_next = PH_SKIP;
            end else if (hex.valid) begin
              if (size_overflow) begin
                terminator_bad_next = 1'b1;
              end else begin
                chunk_remaining_next = {chunk_remaining[SIZE_BITS-5:0], hex.value};
              end
            end else begin
              terminator_bad_next = 1'b1;
              phase_next          = PH_SKIP;
            end
          end
        end
        PH_DATA: begin
          chunk_remaining_next = chunk_remaining - SIZE_BITS'(1);
          if (chunk_remaining == SIZE_BITS'(1)) begin
            phase_next = PH_CR;
          end
        end
        PH_CR: begin
          terminator_bad_next = (byte_in != CH_CR);
          phase_next          = PH_LF;
        end
        PH_LF: begin
          if (terminator_bad || byte_in != CH_LF) begin
            sticky_error_next = ERR_FRAMING;
            phase_next        = PH_ERROR;
          end else begin
            phase_next = PH_FIRST;
          end
        end
        PH_TRAILER: begin
          if (byte_in == CH_LF) begin
            phase_next = PH_DONE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_comb begin
    result.data_valid = !conn_closed && (phase == PH_DATA);
    result.data_byte  = result.data_valid ? byte_in : 8'h00;
    result.finished   = (phase_next == PH_DONE);
    result.error_code = (phase_next == PH_ERROR) ? sticky_error_next : ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FIRST;
      chunk_remaining <= '0;
      terminator_bad  <= 1'b0;
      sticky_error    <= ERR_NONE;
    end else if (accept) begin
      phase           <= phase_next;
      chunk_remaining <= chunk_remaining_next;
      terminator_bad  <= terminator_bad_next;
      sticky_error    <= sticky_error_next;
    end
  end

endmodule

FILE: sv/cbd_out_reg.sv
module cbd_out_reg import cbd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result_out
);

  logic    full;
  result_t held;

  assign can_load   = !full || out_ready;
  assign out_valid  = full;
  assign result_out = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result_in;
    end
  end

endmodule

FILE: sv/chunked_body_decoder_top.sv
// Chunked body decoder: takes an HTTP response body one byte per transfer and strips the
// chunked framing, giving exactly one result transfer per input transfer. Each input transfer
// is decoded in the cycle it is accepted and the result lands in a single output register, so
// the block sustains one byte per clock; in_ready drops only while that output register is
// full and out_ready is low. Payload bytes come out with data_valid set; size lines, CR LF
// terminators and the trailer line give data_valid low. A transfer with conn_closed set
// carries no byte and reports truncation (error_code 2) unless decoding has already finished
// or failed. finished and error_code stick until reset.

`include "chunked_body_decoder_top_assert.svh"

module chunked_body_decoder_top import cbd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       conn_closed,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       data_valid,
  output logic       finished,
  output logic [1:0] error_code
);

  // A transfer is taken when it is offered and the output register can accept its result.
  logic    accept;
  result_t step_result;
  result_t out_result;

  assign accept = in_valid && in_ready;

  // Framing state machine; its state advances only on an accepted transfer.
  cbd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .byte_in     (byte_in),
    .conn_closed (conn_closed),
    .result      (step_result)
  );

  // The output register separates the two handshakes; input is held off only while
  // a result waits in it and out_ready is low.
  cbd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .result_in  (step_result),
    .can_load   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (out_result)
  );

  assign data_byte  = out_result.data_byte;
  assign data_valid = out_result.data_valid;
  assign finished   = out_result.finished;
  assign error_code = out_result.error_code;

  // A result never claims both completion and failure.
  `CBD_ASSERT_NOW(a_done_xor_error, clk, rst, out_valid && finished, error_code == ERR_NONE)
  // Payload bytes only appear while decoding is still healthy and unfinished.
  `CBD_ASSERT_NOW(a_data_clean, clk, rst, out_valid && data_valid,
                  !finished && error_code == ERR_NONE)
  // An empty output register always lets the next transfer in.
  `CBD_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  // A result that is not taken stays in the register.
  `CBD_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(error_code) && $stable(finished))

endmodule

FILE: test/tb_chunked_body_decoder_top.sv
module tb_chunked_body_decoder_top;
  import cbd_pkg::*;

  localparam int SIZE_BITS = 32;
  localparam int STREAM_ITEMS = 400;
  localparam int MAX_GAP = 13;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [63:0] CHUNK_LIMIT = (64'd1 << SIZE_BITS) - 64'd1;
  localparam result_t UNTYPED = '0;

  // One input transfer. Rows with typed set carry a hand-written expectation that is used
  // in place of the predicted one; all other rows are checked against the predictor.
  typedef struct {
    logic [7:0] octet;
    logic       closed;
    logic       typed;
    result_t    want;
  } stim_t;

  // Done and error states stick until reset, and reset happens only once, so every run
  // ends the body in exactly one of these ways.
  typedef enum int {
    END_FINISH,
    END_TRUNCATE,
    END_BAD_FIRST,
    END_BAD_DIGIT,
    END_OVERFLOW,
    END_EMPTY_LINE,
    END_BAD_CRLF
  } ending_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] byte_in = 8'h00;
  logic       conn_closed = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       finished;
  logic [1:0] error_code;

  chunked_body_decoder_top #(.SIZE_BITS(SIZE_BITS)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .conn_closed(conn_closed),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .data_valid (data_valid),
    .finished   (finished),
    .error_code (error_code)
  );

  always #10 clk = ~clk;

  // The opening stretch of the body: a two-byte chunk whose size line carries an extension,
  // with the extreme payload values, then a one-byte chunk whose size has leading zeros and
  // runs straight into the LF.
  stim_t directed [16] = '{
    '{8'h32, 1'b0, 1'b1, {8'h00, 1'b0, 1'b0, ERR_NONE}},  // '2' right after reset
    '{CH_SEMI, 1'b0, 1'b0, UNTYPED},
    '{8'h7A, 1'b0, 1'b0, UNTYPED},                         // extension text is skipped
    '{CH_CR, 1'b0, 1'b0, UNTYPED},
    '{CH_LF, 1'b0, 1'b0, UNTYPED},
    '{8'h00, 1'b0, 1'b1, {8'h00, 1'b1, 1'b0, ERR_NONE}},
    '{8'hFF, 1'b0, 1'b1, {8'hFF, 1'b1, 1'b0, ERR_NONE}},
    '{CH_CR, 1'b0, 1'b0, UNTYPED},
    '{CH_LF, 1'b0, 1'b0, UNTYPED},
    '{8'h30, 1'b0, 1'b0, UNTYPED},
    '{8'h30, 1'b0, 1'b0, UNTYPED},
    '{8'h31, 1'b0, 1'b0, UNTYPED},
    '{CH_LF, 1'b0, 1'b0, UNTYPED},
    '{8'h80, 1'b0, 1'b0, UNTYPED},
    '{CH_CR, 1'b0, 1'b0, UNTYPED},
    '{CH_LF, 1'b0, 1'b0, UNTYPED}
  };

  stim_t   body_stream[$];
  result_t awaited_results[$];
  int      accepted = 0;
  int      mismatches = 0;
  int unsigned cycle_count = 0;

  // Predictor state, mirroring the decoder's own registers.
  phase_t               model_phase;
  logic [SIZE_BITS-1:0] model_remaining;
  logic                 model_bad_line;
  logic [1:0]           model_error;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Letters sit one past a multiple of 16 in both cases, so the low nibble plus 9 is the value.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    return (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  // Bytes that end the number of a size line: whitespace, semicolon and NUL.
  function automatic logic ends_size(input logic [7:0] c);
    return c == CH_SP || (c >= CH_TAB && c <= CH_CR) || c == CH_SEMI || c == CH_NUL;
  endfunction

  // A digit that would push the size past SIZE_BITS marks the line bad instead of growing it.
  task automatic take_digit(input logic [3:0] d);
    logic [63:0] acc;
    acc = 64'(model_remaining);
    if (acc > (CHUNK_LIMIT - 64'(d)) / 64'd16) begin
      model_bad_line = 1'b1;
    end else begin
      model_remaining = SIZE_BITS'(acc * 64'd16 + 64'(d));
    end
  endtask

  task automatic model_fail(input logic [1:0] code);
    model_error = code;
    model_phase = PH_ERROR;
  endtask

  task automatic end_size_line();
    if (model_bad_line) begin
      model_fail(ERR_FRAMING);
    end else begin
      model_phase = (model_remaining == '0) ? PH_TRAILER : PH_DATA;
    end
  endtask

  // Advances the predictor by one accepted transfer and returns the result it must cause.
  task automatic decode_byte(input logic [7:0] c, input logic closed, output result_t r);
    r = '0;
    if (model_phase != PH_DONE && model_phase != PH_ERROR && closed) begin
      model_fail(ERR_TRUNCATED);
    end else if (!closed) begin
      case (model_phase)
        PH_FIRST: begin
          model_remaining = '0;
          model_bad_line = 1'b0;
          if (c == CH_LF) begin
            model_fail(ERR_FRAMING);
          end else if (is_hex(c)) begin
            take_digit(hex_value(c));
            model_phase = PH_DIGITS;
          end else begin
            model_bad_line = 1'b1;
            model_phase = PH_SKIP;
          end
        end
        PH_DIGITS: begin
          if (c == CH_LF) begin
            end_size_line();
          end else if (ends_size(c)) begin
            model_phase = PH_SKIP;
          end else if (is_hex(c)) begin
            take_digit(hex_value(c));
          end else begin
            model_bad_line = 1'b1;
            model_phase = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (c == CH_LF) end_size_line();
        end
        PH_DATA: begin
          r.data_byte = c;
          r.data_valid = 1'b1;
          model_remaining = model_remaining - 1'b1;
          if (model_remaining == '0) model_phase = PH_CR;
        end
        PH_CR: begin
          model_bad_line = (c != CH_CR);
          model_phase = PH_LF;
        end
        PH_LF: begin
          if (model_bad_line || c != CH_LF) model_fail(ERR_FRAMING);
          else model_phase = PH_FIRST;
        end
        PH_TRAILER: begin
          if (c == CH_LF) model_phase = PH_DONE;
        end
        default: begin
        end
      endcase
    end
    r.finished = (model_phase == PH_DONE);
    r.error_code = (model_phase == PH_ERROR) ? model_error : ERR_NONE;
  endtask

  task automatic add_byte(input logic [7:0] b, input logic closed);
    stim_t s;
    s.octet = b;
    s.closed = closed;
    s.typed = 1'b0;
    s.want = UNTYPED;
    body_stream.push_back(s);
  endtask

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
    return b;
  endfunction

  // Hex digit character, with letters in a random case.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // Whatever follows the number on a size line: a bare LF, CR LF, or a delimiter and some
  // extension text before the LF.
  task automatic add_line_tail();
    logic [7:0] delims [7];
    delims = '{CH_SP, CH_TAB, 8'h0B, 8'h0C, CH_CR, CH_SEMI, CH_NUL};
    case ($urandom_range(0, 2))
      0: begin
      end
      1: add_byte(CH_CR, 1'b0);
      default: begin
        add_byte(delims[$urandom_range(0, 6)], 1'b0);
        repeat ($urandom_range(0, 4)) add_byte(any_but_lf(), 1'b0);
      end
    endcase
    add_byte(CH_LF, 1'b0);
  endtask

  task automatic add_size_line(input logic [63:0] value);
    int nd;
    nd = 1;
    while (nd < 16 && (value >> (4 * nd)) != 64'd0) nd++;
    // Leading zeros now and then; they never change the value or the overflow check.
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) add_byte(8'h30, 1'b0);
    for (int k = nd - 1; k >= 0; k--) add_byte(hex_char(value[4 * k +: 4]), 1'b0);
    add_line_tail();
  endtask

  task automatic add_payload(input int len);
    add_size_line(64'(len));
    repeat (len) add_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Prediction and checking share one process so that a transfer and its result taken at
  // the same edge are handled in order.
  always @(posedge clk) begin
    result_t predicted;
    result_t got;
    result_t want;
    if (rst) begin
      model_phase = PH_FIRST;
      model_remaining = '0;
      model_bad_line = 1'b0;
      model_error = ERR_NONE;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(byte_in, conn_closed, predicted);
        if (body_stream[accepted].typed) predicted = body_stream[accepted].want;
        awaited_results.push_back(predicted);
        accepted++;
      end
      if (out_valid && out_ready) begin
        got = {data_byte, data_valid, finished, error_code};
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: byte %h valid %b finished %b error %0d",
                     got.data_byte, got.data_valid, got.finished, got.error_code);
        end else begin
          want = awaited_results.pop_front();
          if (got.data_byte !== want.data_byte || got.data_valid !== want.data_valid ||
              got.finished !== want.finished || got.error_code !== want.error_code) begin
            mismatches++;
            // Fields are byte/valid/finished/error.
            if (mismatches <= 10)
              $display("mismatch at %0d: expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
                       cycle_count, want.data_byte, want.data_valid, want.finished,
                       want.error_code, got.data_byte, got.data_valid, got.finished,
                       got.error_code);
          end
        end
      end
    end
  end

  // Receiver. It pauses for a random gap before each result, except for runs where it takes
  // everything at once, and once holds off long enough that the decoder's output register
  // fills and in_ready drops while the sender keeps offering.
  initial begin
    int gap;
    int taken;
    taken = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      else gap = ((taken % 80) >= 50) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sender. The whole body is built first: the directed opening, then well-formed chunks
  // with random sizes, size-line extensions and payload, then one randomly chosen ending,
  // and finally a few transfers after the ending to show that done and error states stick.
  initial begin
    ending_t    ending;
    logic [7:0] b;
    logic [7:0] b2;
    int         gap;
    foreach (directed[k]) body_stream.push_back(directed[k]);
    while (body_stream.size() < 16 + STREAM_ITEMS) begin
      add_payload(($urandom_range(0, 9) == 0) ? $urandom_range(7, 48) : $urandom_range(1, 6));
      add_byte(CH_CR, 1'b0);
      add_byte(CH_LF, 1'b0);
    end

    ending = ending_t'($urandom_range(0, 6));
    case (ending)
      END_FINISH: begin
        // Last chunk, then a trailer line whose content is ignored.
        add_size_line(64'd0);
        repeat ($urandom_range(0, 5)) add_byte(any_but_lf(), 1'b0);
        add_byte(CH_LF, 1'b0);
      end
      END_TRUNCATE: begin
        // Sometimes the largest legal size first, so the connection drops mid-payload.
        if ($urandom_range(0, 1)) begin
          add_size_line(CHUNK_LIMIT);
          repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        add_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      END_BAD_FIRST: begin
        do b = any_but_lf(); while (is_hex(b));
        add_byte(b, 1'b0);
        repeat ($urandom_range(0, 3)) add_byte(any_but_lf(), 1'b0);
        add_byte(CH_LF, 1'b0);
      end
      END_BAD_DIGIT: begin
        add_byte(hex_char(4'($urandom_range(1, 15))), 1'b0);
        do b = 8'($urandom_range(0, 255)); while (is_hex(b) || ends_size(b));
        add_byte(b, 1'b0);
        repeat ($urandom_range(0, 3)) add_byte(any_but_lf(), 1'b0);
        add_byte(CH_LF, 1'b0);
      end
      END_OVERFLOW: begin
        // A nonzero digit followed by SIZE_BITS/4 more digits cannot fit the counter.
        add_byte(hex_char(4'($urandom_range(1, 15))), 1'b0);
        repeat (SIZE_BITS / 4) add_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
        add_line_tail();
      end
      END_EMPTY_LINE: add_byte(CH_LF, 1'b0);
      default: begin
        // Payload followed by a broken CR LF; the error shows on the second byte.
        add_payload($urandom_range(1, 4));
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
        do b2 = 8'($urandom_range(0, 255)); while (b2 == CH_LF);
        case ($urandom_range(0, 2))
          0: begin
            add_byte(b, 1'b0);
            add_byte(CH_LF, 1'b0);
          end
          1: begin
            add_byte(CH_CR, 1'b0);
            add_byte(b2, 1'b0);
          end
          default: begin
            add_byte(b, 1'b0);
            add_byte(b2, 1'b0);
          end
        endcase
      end
    endcase
    add_byte(8'($urandom_range(0, 255)), 1'b1);
    repeat ($urandom_range(5, 10))
      add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Payload changes only at falling edges; valid stays high until the transfer is taken.
    for (int i = 0; i < body_stream.size(); i++) begin
      gap = ((i % 96) >= 64) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      byte_in <= body_stream[i].octet;
      conn_closed <= body_stream[i].closed;
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    // Drain, then watch a little longer for stray results.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
